[rtl/scle_pkg.sv]
`timescale 1ns / 1ps

package scle_pkg;

    localparam int MAP_ENTRIES  = 58;
    localparam int BUFFER_DEPTH = 256;
    localparam int MAX_RESULTS  = 3;

    localparam logic [8:0] CAP_RESET = 9'd256;
    localparam logic [8:0] CAP_MIN   = 9'd2;
    localparam logic [8:0] CAP_MAX   = 9'(BUFFER_DEPTH);

    localparam logic [7:0] STATUS_DATA_READY = 8'h01;
    localparam logic [7:0] STATUS_MOUSE      = 8'h20;
    localparam logic [7:0] SCAN_RELEASE      = 8'h80;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_DEL = 8'h7F;

    localparam logic [2:0] REG_ADDR_LINE_CAPACITY = 3'd0;

    // Set-1 make codes to ASCII; codes past the map read as no character.
    localparam logic [7:0] KEY_TABLE [64] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       line_done;
        logic [7:0] line_length;
        logic       last;
    } result_t;

    localparam result_t RESULT_NONE = '0;

endpackage

[rtl/scle_decode.sv]
`timescale 1ns / 1ps

module scle_decode (
    input  logic [7:0]                   controller_status,
    input  logic [7:0]                   scan_code,
    input  logic [8:0]                   line_capacity,
    input  logic [7:0]                   cursor,
    output logic [1:0]                   result_count,
    output scle_pkg::result_t [2:0]      results,
    output logic [7:0]                   cursor_next
);
    import scle_pkg::*;

    logic       key_ok;
    logic [7:0] ch;
    logic [8:0] cap;
    logic [7:0] lim;
    logic [7:0] cursor_inc;

    always_comb begin
        ch = KEY_TABLE[scan_code[5:0]];
        key_ok = ((controller_status & STATUS_DATA_READY) != '0)
            && ((controller_status & STATUS_MOUSE) == '0)
            && ((scan_code & SCAN_RELEASE) == '0)
            && (scan_code < 8'(MAP_ENTRIES))
            && (ch != CHAR_NUL);

        cap = line_capacity;
        if (cap < CAP_MIN) begin
            cap = CAP_MIN;
        end
        if (cap > CAP_MAX) begin
            cap = CAP_MAX;
        end
        lim = 8'(cap - 9'd1);
        cursor_inc = cursor + 8'd1;

        result_count = 2'd0;
        results = {RESULT_NONE, RESULT_NONE, RESULT_NONE};
        cursor_next = cursor;

        if (key_ok) begin
            if (cursor >= lim) begin
                // Capacity was lowered under the cursor: close the line at the limit.
                result_count = 2'd1;
                results[0].store_valid = 1'b1;
                results[0].store_index = lim;
                results[0].line_done = 1'b1;
                results[0].line_length = lim;
                results[0].last = 1'b1;
                cursor_next = '0;
            end else if (ch == CHAR_LF || ch == CHAR_CR) begin
                result_count = 2'd2;
                results[0].echo_valid = 1'b1;
                results[0].echo_byte = CHAR_CR;
                results[1].echo_valid = 1'b1;
                results[1].echo_byte = CHAR_LF;
                results[1].store_valid = 1'b1;
                results[1].store_index = cursor;
                results[1].line_done = 1'b1;
                results[1].line_length = cursor;
                results[1].last = 1'b1;
                cursor_next = '0;
            end else if (ch == CHAR_BS || ch == CHAR_DEL) begin
                if (cursor != '0) begin
                    result_count = 2'd3;
                    results[0].echo_valid = 1'b1;
                    results[0].echo_byte = CHAR_BS;
                    results[1].echo_valid = 1'b1;
                    results[1].echo_byte = CHAR_SP;
                    results[2].echo_valid = 1'b1;
                    results[2].echo_byte = CHAR_BS;
                    results[2].last = 1'b1;
                    cursor_next = cursor - 8'd1;
                end
            end else begin
                results[0].echo_valid = 1'b1;
                results[0].echo_byte = ch;
                results[0].store_valid = 1'b1;
                results[0].store_index = cursor;
                results[0].store_byte = ch;
                if (cursor_inc >= lim) begin
                    result_count = 2'd2;
                    results[1].store_valid = 1'b1;
                    results[1].store_index = cursor_inc;
                    results[1].line_done = 1'b1;
                    results[1].line_length = cursor_inc;
                    results[1].last = 1'b1;
                    cursor_next = '0;
                end else begin
                    result_count = 2'd1;
                    results[0].last = 1'b1;
                    cursor_next = cursor_inc;
                end
            end
        end
    end

endmodule

[rtl/scle_out.sv]
`timescale 1ns / 1ps

module scle_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [1:0]                   load_count,
    input  scle_pkg::result_t [2:0]      load_results,
    output logic                         can_load,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,
    output logic                         m_tlast
);
    import scle_pkg::*;

    result_t [2:0] plan_reg;
    result_t [2:0] plan_next;
    logic [1:0]    rem_reg;
    logic [1:0]    rem_next;
    result_t       head;

    assign m_tvalid = (rem_reg != 2'd0);
    assign can_load = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_tready);
    assign head = plan_reg[0];

    always_comb begin
        plan_next = plan_reg;
        rem_next = rem_reg;
        if (load) begin
            plan_next = load_results;
            rem_next = load_count;
        end else if (m_tvalid && m_tready) begin
            plan_next = {RESULT_NONE, plan_reg[2], plan_reg[1]};
            rem_next = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        plan_reg <= plan_next;
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    assign m_tdata = {5'd0, head.line_length, head.line_done, head.store_byte,
                      head.store_index, head.store_valid, head.echo_byte,
                      head.echo_valid};
    assign m_tlast = head.last;

endmodule

[rtl/scancode_line_editor_top.sv]
`timescale 1ns / 1ps

// A request taken on s_tdata is held in the input register and then loaded into the result
// register, from which its first result is offered.
// Requests flow at one per cycle while each yields at most one result and m_tready is high;
// a request that yields n results holds the result register until all n are taken, one
// result a cycle while m_tready is high. Reset (aresetn low at a clock edge) empties both
// registers, clears the cursor and sets line_capacity to 256.
module scancode_line_editor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] controller_status, [15:8] scan_code
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] echo_valid, [8:1] echo_byte, [9] store_valid, [17:10] store_index,
    // [25:18] store_byte, [26] line_done, [34:27] line_length, [39:35] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    import scle_pkg::*;

    logic [8:0]    cap_reg;
    logic [7:0]    cursor_reg;
    logic [7:0]    cursor_next;
    logic          in_valid_reg;
    logic [15:0]   in_data_reg;
    logic          can_load;
    logic          consume;
    logic          cfg_write;
    logic [1:0]    result_count;
    result_t [2:0] results;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
        && ({paddr[2], 2'b00} == REG_ADDR_LINE_CAPACITY);
    assign prdata = ({paddr[2], 2'b00} == REG_ADDR_LINE_CAPACITY)
        ? {23'd0, cap_reg} : 32'd0;

    assign consume = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || consume;

    scle_decode u_decode (
        .controller_status (in_data_reg[7:0]),
        .scan_code         (in_data_reg[15:8]),
        .line_capacity     (cap_reg),
        .cursor            (cursor_reg),
        .result_count      (result_count),
        .results           (results),
        .cursor_next       (cursor_next)
    );

    scle_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (consume),
        .load_count   (result_count),
        .load_results (results),
        .can_load     (can_load),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
            cursor_reg <= '0;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                cap_reg <= pwdata[8:0];
            end
            if (consume) begin
                cursor_reg <= cursor_next;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

endmodule
